@@ hw/rtl/hbrp_pkg.sv @@
// Shared types and constants for the HTTP byte-range parser.
// Used by http_byte_range_parser and hbrp_checker; no other dependencies.

package hbrp_pkg;

  localparam int unsigned NUM_W  = 64;  // strtoull value width
  localparam int unsigned SIZE_W = 63;  // file size and offset width
  localparam int unsigned WIDE_W = NUM_W + 4;  // room for value * 10 + digit

  // Parse phases, one-hot
  typedef enum logic [9:0] {
    PH_PREFIX  = 10'b00_0000_0001,
    PH_SKIPSP  = 10'b00_0000_0010,
    PH_N1_WS   = 10'b00_0000_0100,
    PH_N1_DIG  = 10'b00_0000_1000,
    PH_DASH    = 10'b00_0001_0000,
    PH_N2_WS   = 10'b00_0010_0000,
    PH_N2_DIG  = 10'b00_0100_0000,
    PH_SFX_WS  = 10'b00_1000_0000,
    PH_SFX_DIG = 10'b01_0000_0000,
    PH_DONE    = 10'b10_0000_0000
  } phase_t;

  // Verdict codes
  localparam logic [1:0] VERDICT_OK    = 2'd0;
  localparam logic [1:0] VERDICT_UNSAT = 2'd1;
  localparam logic [1:0] VERDICT_WHOLE = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] PREFIX_LAST = 3'd5;  // position of '=' in "bytes="

  // Expected character at each position of "bytes="
  function automatic logic [7:0] lead_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h62;  // b
      3'd1:    ch = 8'h79;  // y
      3'd2:    ch = 8'h74;  // t
      3'd3:    ch = 8'h65;  // e
      3'd4:    ch = 8'h73;  // s
      3'd5:    ch = 8'h3D;  // =
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

@@ hw/rtl/http_byte_range_parser.sv @@
// HTTP single byte-range parser, top level.
// Depends on hbrp_pkg for phase type, verdict codes and character constants.

// The block takes a Range header one byte per transfer on the in_ channel, then
// one end transfer (in_is_end = 1) that carries the file size. While in_ready
// is high, each transfer is taken as offered and a new one may follow, so the
// sustained rate is one item per clock. Header bytes give no result; the end
// transfer gives exactly one result, registered and shown on the out_ channel
// from the next cycle on. The path that sets the clock is the per-byte
// multiply-by-ten-and-add on the 64-bit number under construction, plus the
// clamp compares on the end transfer. in_ready drops only while a finished
// result waits and out_ready is low; a result being taken in the same cycle
// does not stall the input. After each end transfer all parse state returns
// to its reset values, ready for the next header. An absent header is sent
// as an end transfer alone and yields the serve-whole-file verdict.

module http_byte_range_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_header_char,
  input  logic                          in_is_end,
  input  logic [hbrp_pkg::SIZE_W-1:0]   in_file_size,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_verdict,
  output logic [hbrp_pkg::SIZE_W-1:0]   out_range_start,
  output logic [hbrp_pkg::SIZE_W-1:0]   out_range_end
);

  localparam int unsigned NW = hbrp_pkg::NUM_W;
  localparam int unsigned WW = hbrp_pkg::WIDE_W;

  // Parse state
  hbrp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]    prefix_pos_r, prefix_pos_nxt;
  logic          comma_r, comma_nxt;
  logic          syntax_err_r, syntax_err_nxt;
  logic          suffix_r, suffix_nxt;
  logic          text_ended_r, text_ended_nxt;
  logic          digit_r, digit_nxt;
  logic          neg_r, neg_nxt;
  logic          ovf_r, ovf_nxt;
  logic [NW-1:0] first_r, first_nxt;
  logic [NW-1:0] second_r, second_nxt;

  // Result register
  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  verdict_r, verdict_nxt;
  logic [hbrp_pkg::SIZE_W-1:0] start_r, start_nxt;
  logic [hbrp_pkg::SIZE_W-1:0] end_r, end_nxt;

  logic in_xfer, char_xfer, end_xfer;

  // A waiting result only blocks when it is not being taken this cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign char_xfer = in_xfer && !in_is_end;
  assign end_xfer  = in_xfer && in_is_end;

  // ---------------------------------------------------------------------
  // Shared number unit: one strtoull step on whichever number is open.
  // ---------------------------------------------------------------------
  logic [7:0]    ch;
  logic          c_ws, c_dig;
  logic          in_n1_grp, in_sfx_grp, fresh, ws_mode;
  logic [NW-1:0] op_v;
  logic          op_dig, op_neg, op_ovf;
  logic [WW-1:0] op_wide, mul;
  logic          mul_ovf;
  logic          take_ws, take_plus, take_minus, take;
  logic [NW-1:0] num_v;
  logic          num_dig, num_neg, num_ovf;
  logic          fin_ok;
  logic [NW-1:0] fin_v;

  assign ch    = in_header_char;
  assign c_ws  = (ch == hbrp_pkg::CH_SPACE) ||
                 ((ch >= hbrp_pkg::CH_TAB) && (ch <= hbrp_pkg::CH_CR));
  assign c_dig = (ch >= hbrp_pkg::CH_ZERO) && (ch <= hbrp_pkg::CH_NINE);

  // SKIPSP (on a non-space, non-dash byte) and DASH open a new number.
  assign fresh      = (phase_r == hbrp_pkg::PH_SKIPSP) || (phase_r == hbrp_pkg::PH_DASH);
  assign in_n1_grp  = (phase_r == hbrp_pkg::PH_SKIPSP) || (phase_r == hbrp_pkg::PH_N1_WS) ||
                      (phase_r == hbrp_pkg::PH_N1_DIG);
  assign in_sfx_grp = (phase_r == hbrp_pkg::PH_SFX_WS) || (phase_r == hbrp_pkg::PH_SFX_DIG);
  assign ws_mode    = fresh || (phase_r == hbrp_pkg::PH_N1_WS) ||
                      (phase_r == hbrp_pkg::PH_N2_WS) || (phase_r == hbrp_pkg::PH_SFX_WS);

  assign op_v   = fresh ? '0 : (in_n1_grp ? first_r : second_r);
  assign op_dig = !fresh && digit_r;
  assign op_neg = !fresh && neg_r;
  assign op_ovf = !fresh && ovf_r;

  // value * 10 + digit, with four spare bits to flag a 64-bit overflow
  assign op_wide = {4'b0000, op_v};
  assign mul     = (op_wide << 3) + (op_wide << 1) + {{(WW-4){1'b0}}, ch[3:0]};
  assign mul_ovf = |mul[WW-1:NW];

  assign take_ws    = ws_mode && c_ws;
  assign take_plus  = ws_mode && (ch == hbrp_pkg::CH_PLUS);
  assign take_minus = ws_mode && (ch == hbrp_pkg::CH_MINUS);
  assign take       = take_ws || take_plus || take_minus || c_dig;

  assign num_v   = (c_dig && !mul_ovf) ? mul[NW-1:0] : op_v;
  assign num_dig = op_dig || c_dig;
  assign num_neg = op_neg || take_minus;
  assign num_ovf = op_ovf || (c_dig && mul_ovf);

  // Number closed by a byte it does not take: usable and sign applied?
  assign fin_ok = op_dig && !op_ovf;
  assign fin_v  = op_neg ? (NW'(0) - op_v) : op_v;

  // ---------------------------------------------------------------------
  // Per-byte parse step
  // ---------------------------------------------------------------------
  always_comb begin
    phase_nxt      = phase_r;
    prefix_pos_nxt = prefix_pos_r;
    comma_nxt      = comma_r;
    syntax_err_nxt = syntax_err_r;
    suffix_nxt     = suffix_r;
    text_ended_nxt = text_ended_r;
    digit_nxt      = digit_r;
    neg_nxt        = neg_r;
    ovf_nxt        = ovf_r;
    first_nxt      = first_r;
    second_nxt     = second_r;

    if (end_xfer) begin
      // Header finished: back to reset values for the next one.
      phase_nxt      = hbrp_pkg::PH_PREFIX;
      prefix_pos_nxt = '0;
      comma_nxt      = 1'b0;
      syntax_err_nxt = 1'b0;
      suffix_nxt     = 1'b0;
      text_ended_nxt = 1'b0;
      digit_nxt      = 1'b0;
      neg_nxt        = 1'b0;
      ovf_nxt        = 1'b0;
    end else if (char_xfer && !text_ended_r) begin
      if (ch == hbrp_pkg::CH_NUL) begin
        // NUL ends the text; drop everything up to the end transfer.
        text_ended_nxt = 1'b1;
      end else begin
        if ((phase_r != hbrp_pkg::PH_PREFIX) && (ch == hbrp_pkg::CH_COMMA)) begin
          comma_nxt = 1'b1;
        end
        unique case (phase_r)
          hbrp_pkg::PH_PREFIX: begin
            if (ch == hbrp_pkg::lead_char(prefix_pos_r)) begin
              prefix_pos_nxt = prefix_pos_r + 3'd1;
              if (prefix_pos_r == hbrp_pkg::PREFIX_LAST) begin
                phase_nxt = hbrp_pkg::PH_SKIPSP;
              end
            end else begin
              syntax_err_nxt = 1'b1;
              phase_nxt      = hbrp_pkg::PH_DONE;
            end
          end
          hbrp_pkg::PH_SKIPSP, hbrp_pkg::PH_N1_WS, hbrp_pkg::PH_N1_DIG: begin
            if ((phase_r == hbrp_pkg::PH_SKIPSP) && (ch == hbrp_pkg::CH_SPACE)) begin
              // hold: skip spaces after the prefix
            end else if ((phase_r == hbrp_pkg::PH_SKIPSP) &&
                         (ch == hbrp_pkg::CH_MINUS)) begin
              // Suffix form "-N": the number goes to the second slot.
              suffix_nxt = 1'b1;
              second_nxt = '0;
              digit_nxt  = 1'b0;
              neg_nxt    = 1'b0;
              ovf_nxt    = 1'b0;
              phase_nxt  = hbrp_pkg::PH_SFX_WS;
            end else if (take) begin
              first_nxt = num_v;
              digit_nxt = num_dig;
              neg_nxt   = num_neg;
              ovf_nxt   = num_ovf;
              phase_nxt = take_ws ? hbrp_pkg::PH_N1_WS : hbrp_pkg::PH_N1_DIG;
            end else if (fin_ok && (ch == hbrp_pkg::CH_MINUS)) begin
              first_nxt = fin_v;
              phase_nxt = hbrp_pkg::PH_DASH;
            end else begin
              syntax_err_nxt = 1'b1;
              phase_nxt      = hbrp_pkg::PH_DONE;
            end
          end
          hbrp_pkg::PH_DASH, hbrp_pkg::PH_N2_WS, hbrp_pkg::PH_N2_DIG,
          hbrp_pkg::PH_SFX_WS, hbrp_pkg::PH_SFX_DIG: begin
            if (take) begin
              second_nxt = num_v;
              digit_nxt  = num_dig;
              neg_nxt    = num_neg;
              ovf_nxt    = num_ovf;
              if (in_sfx_grp) begin
                phase_nxt = take_ws ? hbrp_pkg::PH_SFX_WS : hbrp_pkg::PH_SFX_DIG;
              end else begin
                phase_nxt = take_ws ? hbrp_pkg::PH_N2_WS : hbrp_pkg::PH_N2_DIG;
              end
            end else if (fin_ok) begin
              // Trailing text after the last number is ignored, but for commas.
              second_nxt = fin_v;
              phase_nxt  = hbrp_pkg::PH_DONE;
            end else begin
              syntax_err_nxt = 1'b1;
              phase_nxt      = hbrp_pkg::PH_DONE;
            end
          end
          hbrp_pkg::PH_DONE: begin
            // hold: only commas still matter, handled above
          end
          default: begin
            phase_nxt = hbrp_pkg::PH_DONE;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Verdict on the end transfer
  // ---------------------------------------------------------------------
  logic          in_n2;
  logic          early;
  logic          bad;
  logic [NW-1:0] sec_v, size, size_m1, last0, last;
  logic [1:0]    verdict_c;
  logic [NW-1:0] start_c, end_c;

  assign in_n2 = (phase_r == hbrp_pkg::PH_N2_WS) || (phase_r == hbrp_pkg::PH_N2_DIG) ||
                 (phase_r == hbrp_pkg::PH_SFX_WS) || (phase_r == hbrp_pkg::PH_SFX_DIG);
  assign early = (phase_r == hbrp_pkg::PH_PREFIX) || (phase_r == hbrp_pkg::PH_SKIPSP) ||
                 (phase_r == hbrp_pkg::PH_N1_WS) || (phase_r == hbrp_pkg::PH_N1_DIG);
  // A number still open at the end is closed here.
  assign bad   = syntax_err_r || comma_r || early || (in_n2 && !(digit_r && !ovf_r));
  assign sec_v = (in_n2 && neg_r) ? (NW'(0) - second_r) : second_r;

  assign size    = {1'b0, in_file_size};
  assign size_m1 = size - NW'(1);
  // "A-" with nothing after it runs to the last byte of the file.
  assign last0   = (phase_r == hbrp_pkg::PH_DASH) ? size_m1 : sec_v;
  assign last    = (last0 >= size) ? size_m1 : last0;

  always_comb begin
    verdict_c = hbrp_pkg::VERDICT_OK;
    start_c   = '0;
    end_c     = '0;
    if (bad) begin
      verdict_c = hbrp_pkg::VERDICT_WHOLE;
    end else if (suffix_r) begin
      if ((sec_v == '0) || (size == '0)) begin
        verdict_c = hbrp_pkg::VERDICT_UNSAT;
      end else begin
        start_c = (sec_v < size) ? (size - sec_v) : '0;
        end_c   = size_m1;
      end
    end else if (size == '0) begin
      verdict_c = hbrp_pkg::VERDICT_UNSAT;
    end else if (first_r > last) begin
      verdict_c = hbrp_pkg::VERDICT_UNSAT;
    end else begin
      start_c = first_r;
      end_c   = last;
    end
  end

  // Result register: load on the end transfer, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    verdict_nxt   = verdict_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    if (end_xfer) begin
      out_valid_nxt = 1'b1;
      verdict_nxt   = verdict_c;
      start_nxt     = start_c[hbrp_pkg::SIZE_W-1:0];
      end_nxt       = end_c[hbrp_pkg::SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= hbrp_pkg::PH_PREFIX;
      prefix_pos_r <= '0;
      comma_r      <= 1'b0;
      syntax_err_r <= 1'b0;
      suffix_r     <= 1'b0;
      text_ended_r <= 1'b0;
      digit_r      <= 1'b0;
      neg_r        <= 1'b0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      prefix_pos_r <= prefix_pos_nxt;
      comma_r      <= comma_nxt;
      syntax_err_r <= syntax_err_nxt;
      suffix_r     <= suffix_nxt;
      text_ended_r <= text_ended_nxt;
      digit_r      <= digit_nxt;
      neg_r        <= neg_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    first_r   <= first_nxt;
    second_r  <= second_nxt;
    verdict_r <= verdict_nxt;
    start_r   <= start_nxt;
    end_r     <= end_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_verdict     = verdict_r;
  assign out_range_start = start_r;
  assign out_range_end   = end_r;

endmodule

@@ hw/rtl/hbrp_checker.sv @@
// Port-level assertions for http_byte_range_parser, bound to the top level.
// Depends on hbrp_pkg for verdict codes and widths.

module hbrp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_is_end,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_verdict,
  input logic [hbrp_pkg::SIZE_W-1:0] out_range_start,
  input logic [hbrp_pkg::SIZE_W-1:0] out_range_end
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict) &&
      $stable(out_range_start) && $stable(out_range_end))
    else $error("result changed while stalled");

  // Every end transfer yields a result in the next cycle.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_end |=> out_valid)
    else $error("end transfer gave no result");

  // A header byte never produces a result.
  a_char_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_is_end && (!out_valid || out_ready) |=> !out_valid)
    else $error("result appeared without an end transfer");

  // Offsets are zero unless the range is satisfiable.
  a_zero_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict != hbrp_pkg::VERDICT_OK) |->
      (out_range_start == '0) && (out_range_end == '0))
    else $error("offsets set on a non-satisfiable verdict");

  // A satisfiable range is well ordered and the verdict code is legal.
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict <= hbrp_pkg::VERDICT_WHOLE) &&
      ((out_verdict != hbrp_pkg::VERDICT_OK) || (out_range_start <= out_range_end)))
    else $error("bad verdict code or inverted range");

endmodule

bind http_byte_range_parser hbrp_checker u_hbrp_checker (.*);
